>>> rtl/photon_cluster_select_p4_top_defines.svh
// assertion macros for the photon cluster selection block
// included by photon_cluster_select_p4_top, expects i_clk and i_rst_n in scope
`ifndef PHOTON_CLUSTER_SELECT_P4_TOP_DEFINES_SVH
`define PHOTON_CLUSTER_SELECT_P4_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCS_P4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PCS_P4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pcs_p4_pkg.sv
// shared constants and types for the photon cluster selection block
// used by pcs_p4_sine and photon_cluster_select_p4_top, no dependencies
package pcs_p4_pkg;

    // odd-power series coefficients of the quarter-wave sine, unsigned Q30
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [29:0] SIN_C3 = 30'd693598668;
    localparam logic [26:0] SIN_C5 = 27'd85569306;
    localparam logic [22:0] SIN_C7 = 23'd5026995;
    localparam logic [17:0] SIN_C9 = 18'd172272;

    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [14:0] QUARTER_X    = 15'd16384;
    localparam logic [15:0] ONE_Q15      = 16'h8000;
    localparam logic [32:0] HALF_Q15     = 33'd16384;

    // register stages inside the sine unit and in the whole pipeline
    localparam int SIN_STAGES  = 7;
    localparam int PIPE_STAGES = SIN_STAGES + 3;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BARREL_E_MIN  = 3'd0,
        CFG_ENDCAP_E_MIN  = 3'd1,
        CFG_BARREL_COS    = 3'd2,
        CFG_ENDCAP_COS_LO = 3'd3,
        CFG_ENDCAP_COS_HI = 3'd4
    } t_cfg_idx;

endpackage

>>> rtl/pcs_p4_sine.sv
// pipelined Q1.15 sine of a 16-bit turn fraction, quarter-wave odd series
// uses pcs_p4_pkg; per-stage enables come from the top level valid chain
module pcs_p4_sine (
    input  logic                                 i_clk,
    input  logic [pcs_p4_pkg::SIN_STAGES-1:0]    i_en,
    input  logic [15:0]                          i_angle,
    output logic signed [16:0]                   o_value
);

    // stage 1: fold into first quadrant, square
    logic [1:0]  n_quad;
    logic [14:0] n_x;
    logic [30:0] n_x2;

    logic        r_neg1, r_neg2, r_neg3, r_neg4, r_neg5, r_neg6;
    logic [14:0] r_x1, r_x2v, r_x3, r_x4, r_x5;
    logic [30:0] r_xx1, r_xx2, r_xx3, r_xx4;
    logic [22:0] r_t7;
    logic [26:0] r_t5;
    logic [29:0] r_t3;
    logic [30:0] r_t1;
    logic [31:0] r_m;
    logic signed [16:0] r_value;

    logic [48:0] n_p2;
    logic [53:0] n_p3;
    logic [57:0] n_p4;
    logic [60:0] n_p5;
    logic [45:0] n_p6;
    logic [22:0] n_t7;
    logic [26:0] n_t5;
    logic [29:0] n_t3;
    logic [30:0] n_t1;
    logic [32:0] n_rnd;
    logic [17:0] n_mag18;
    logic [15:0] n_mag;
    logic signed [16:0] n_value;

    assign n_quad = i_angle[15:14];
    assign n_x    = n_quad[0] ? (pcs_p4_pkg::QUARTER_X - 15'(i_angle[13:0]))
                              : 15'(i_angle[13:0]);
    // x squared in Q30 is 4 * x * x, exact
    assign n_x2   = {29'(32'(n_x) * 32'(n_x)), 2'b00};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg1 <= n_quad[1];
            r_x1   <= n_x;
            r_xx1  <= n_x2;
        end
    end

    // stages 2..5: Horner steps, each product truncated to Q30
    assign n_p2 = 49'(r_xx1) * 49'(pcs_p4_pkg::SIN_C9);
    assign n_t7 = pcs_p4_pkg::SIN_C7 - 23'(n_p2[48:30]);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_neg2 <= r_neg1;
            r_x2v  <= r_x1;
            r_xx2  <= r_xx1;
            r_t7   <= n_t7;
        end
    end

    assign n_p3 = 54'(r_xx2) * 54'(r_t7);
    assign n_t5 = pcs_p4_pkg::SIN_C5 - 27'(n_p3[53:30]);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_neg3 <= r_neg2;
            r_x3   <= r_x2v;
            r_xx3  <= r_xx2;
            r_t5   <= n_t5;
        end
    end

    assign n_p4 = 58'(r_xx3) * 58'(r_t5);
    assign n_t3 = pcs_p4_pkg::SIN_C3 - 30'(n_p4[57:30]);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_neg4 <= r_neg3;
            r_x4   <= r_x3;
            r_xx4  <= r_xx3;
            r_t3   <= n_t3;
        end
    end

    assign n_p5 = 61'(r_xx4) * 61'(r_t3);
    assign n_t1 = pcs_p4_pkg::SIN_C1 - 31'(n_p5[60:30]);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_neg5 <= r_neg4;
            r_x5   <= r_x4;
            r_t1   <= n_t1;
        end
    end

    // stage 6: x * t in Q30 is (x * t) >> 14
    assign n_p6 = 46'(r_x5) * 46'(r_t1);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_neg6 <= r_neg5;
            r_m    <= n_p6[45:14];
        end
    end

    // stage 7: round half up to Q1.15, cap at one, apply quadrant sign
    assign n_rnd   = 33'(r_m) + pcs_p4_pkg::HALF_Q15;
    assign n_mag18 = n_rnd[32:15];
    assign n_mag   = (n_mag18 > 18'(pcs_p4_pkg::ONE_Q15)) ? pcs_p4_pkg::ONE_Q15
                                                           : n_mag18[15:0];
    assign n_value = r_neg6 ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

>>> rtl/photon_cluster_select_p4_top.sv
// photon cluster selection and four-momentum, top level
// uses pcs_p4_pkg, pcs_p4_sine and photon_cluster_select_p4_top_defines.svh
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------------
//  in      | i_in_valid / o_in_stall  | i_cluster_energy, i_polar_angle,
//          |                          | i_azimuth_angle
//  out     | o_out_valid / i_out_stall| o_accepted, o_bad_shower, o_mom_x, o_mom_y,
//          |                          | o_mom_z, o_total_energy
//  cfg     | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while i_out_stall is low; ten register stages:
// 7 in the four sine units (folding, five series multiplies, rounding),
// then cut products, momentum products, final rounding into the output register.
// each stage moves when it is empty or the stage after it moves, so bubbles are
// squeezed out and items keep entering while a result waits at the output.
// synchronous active-low reset clears all valid bits and loads the default cuts.
`include "photon_cluster_select_p4_top_defines.svh"

module photon_cluster_select_p4_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [15:0]                           i_cluster_energy,
    input  logic [15:0]                           i_polar_angle,
    input  logic [15:0]                           i_azimuth_angle,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_accepted,
    output logic                                  o_bad_shower,
    output logic signed [16:0]                    o_mom_x,
    output logic signed [16:0]                    o_mom_y,
    output logic signed [16:0]                    o_mom_z,
    output logic [15:0]                           o_total_energy,

    input  logic                                  i_cfg_we,
    input  logic [pcs_p4_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [15:0]                           i_cfg_data
);

    localparam int NS = pcs_p4_pkg::PIPE_STAGES;
    localparam int SS = pcs_p4_pkg::SIN_STAGES;

    localparam logic [15:0] RST_BARREL_E_MIN  = 16'd410;
    localparam logic [15:0] RST_ENDCAP_E_MIN  = 16'd819;
    localparam logic [15:0] RST_BARREL_COS    = 16'd26214;
    localparam logic [15:0] RST_ENDCAP_COS_LO = 16'd28180;
    localparam logic [15:0] RST_ENDCAP_COS_HI = 16'd30147;

    localparam logic signed [32:0] RND15_POS = 33'sd16384;
    localparam logic signed [32:0] RND15_NEG = 33'sd16383;
    localparam logic signed [49:0] RND30_POS = 50'sd536870912;
    localparam logic signed [49:0] RND30_NEG = 50'sd536870911;

    // configuration registers
    logic [15:0] r_barrel_e_min, r_endcap_e_min;
    logic [15:0] r_barrel_cos, r_endcap_cos_lo, r_endcap_cos_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_barrel_e_min  <= RST_BARREL_E_MIN;
            r_endcap_e_min  <= RST_ENDCAP_E_MIN;
            r_barrel_cos    <= RST_BARREL_COS;
            r_endcap_cos_lo <= RST_ENDCAP_COS_LO;
            r_endcap_cos_hi <= RST_ENDCAP_COS_HI;
        end else if (i_cfg_we) begin
            case (pcs_p4_pkg::t_cfg_idx'(i_cfg_idx))
                pcs_p4_pkg::CFG_BARREL_E_MIN:  r_barrel_e_min  <= i_cfg_data;
                pcs_p4_pkg::CFG_ENDCAP_E_MIN:  r_endcap_e_min  <= i_cfg_data;
                pcs_p4_pkg::CFG_BARREL_COS:    r_barrel_cos    <= i_cfg_data;
                pcs_p4_pkg::CFG_ENDCAP_COS_LO: r_endcap_cos_lo <= i_cfg_data;
                pcs_p4_pkg::CFG_ENDCAP_COS_HI: r_endcap_cos_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain and per-stage enables
    logic [NS:1] r_v;
    logic [NS:1] n_v;
    logic [NS:1] w_en;

    assign w_en[NS] = !r_v[NS] || !i_out_stall;

    genvar g;
    for (g = 1; g < NS; g++) begin : g_en
        assign w_en[g] = !r_v[g] || w_en[g+1];
    end

    assign n_v = {r_v[NS-1:1], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~w_en) | (n_v & w_en);
        end
    end

    assign o_in_stall = !w_en[1];

    // energy travels alongside the sine units
    logic [15:0] r_e_dly [1:SS];

    for (g = 1; g <= SS; g++) begin : g_edly
        if (g == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en[g]) begin
                    r_e_dly[g] <= i_cluster_energy;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (w_en[g]) begin
                    r_e_dly[g] <= r_e_dly[g-1];
                end
            end
        end
    end

    // four sine units: sin and cos of theta and of phi
    logic [15:0] w_theta_c, w_phi_c;
    logic signed [16:0] w_st, w_ct, w_sp, w_cp;

    assign w_theta_c = i_polar_angle + pcs_p4_pkg::QUARTER_TURN;
    assign w_phi_c   = i_azimuth_angle + pcs_p4_pkg::QUARTER_TURN;

    pcs_p4_sine u_sin_theta (
        .i_clk   (i_clk),
        .i_en    (w_en[SS:1]),
        .i_angle (i_polar_angle),
        .o_value (w_st)
    );

    pcs_p4_sine u_cos_theta (
        .i_clk   (i_clk),
        .i_en    (w_en[SS:1]),
        .i_angle (w_theta_c),
        .o_value (w_ct)
    );

    pcs_p4_sine u_sin_phi (
        .i_clk   (i_clk),
        .i_en    (w_en[SS:1]),
        .i_angle (i_azimuth_angle),
        .o_value (w_sp)
    );

    pcs_p4_sine u_cos_phi (
        .i_clk   (i_clk),
        .i_en    (w_en[SS:1]),
        .i_angle (w_phi_c),
        .o_value (w_cp)
    );

    // stage 8: cuts, E*sin(theta), E*cos(theta)
    logic [15:0]        n_acos;
    logic [16:0]        n_ct_abs;
    logic               n_barrel, n_window, n_endcap;
    logic signed [16:0] n_e_s;
    logic signed [32:0] n_es8, n_ez8;

    logic               r_acc8, r_win8;
    logic [15:0]        r_e8;
    logic signed [32:0] r_es8, r_ez8;
    logic signed [16:0] r_sp8, r_cp8;

    assign n_ct_abs = w_ct[16] ? 17'(-w_ct) : 17'(w_ct);
    assign n_acos   = n_ct_abs[15:0];
    assign n_barrel = (n_acos < r_barrel_cos) && (r_e_dly[SS] > r_barrel_e_min);
    assign n_window = (n_acos > r_endcap_cos_lo) && (n_acos < r_endcap_cos_hi);
    assign n_endcap = n_window && (r_e_dly[SS] > r_endcap_e_min);
    assign n_e_s    = $signed({1'b0, r_e_dly[SS]});
    assign n_es8    = 33'(n_e_s) * 33'(w_st);
    assign n_ez8    = 33'(n_e_s) * 33'(w_ct);

    always_ff @(posedge i_clk) begin
        if (w_en[SS+1]) begin
            r_acc8 <= n_barrel || n_endcap;
            r_win8 <= n_window;
            r_e8   <= r_e_dly[SS];
            r_es8  <= n_es8;
            r_ez8  <= n_ez8;
            r_sp8  <= w_sp;
            r_cp8  <= w_cp;
        end
    end

    // stage 9: transverse products, longitudinal rounding
    // half away from zero: negative values get a bias one short of half
    logic signed [49:0] n_px9, n_py9;
    logic signed [32:0] n_pz_sum;

    logic               r_acc9, r_win9;
    logic [15:0]        r_e9;
    logic signed [49:0] r_px9, r_py9;
    logic signed [16:0] r_pz9;

    assign n_px9    = 50'(r_es8) * 50'(r_cp8);
    assign n_py9    = 50'(r_es8) * 50'(r_sp8);
    assign n_pz_sum = r_ez8 + (r_ez8[32] ? RND15_NEG : RND15_POS);

    always_ff @(posedge i_clk) begin
        if (w_en[SS+2]) begin
            r_acc9 <= r_acc8;
            r_win9 <= r_win8;
            r_e9   <= r_e8;
            r_px9  <= n_px9;
            r_py9  <= n_py9;
            r_pz9  <= n_pz_sum[31:15];
        end
    end

    // stage 10: transverse rounding, rejected items forced to zero
    logic signed [49:0] n_px_sum, n_py_sum;

    logic               r_out_acc, r_out_bad;
    logic signed [16:0] r_out_mx, r_out_my, r_out_mz;
    logic [15:0]        r_out_e;

    assign n_px_sum = r_px9 + (r_px9[49] ? RND30_NEG : RND30_POS);
    assign n_py_sum = r_py9 + (r_py9[49] ? RND30_NEG : RND30_POS);

    always_ff @(posedge i_clk) begin
        if (w_en[NS]) begin
            r_out_acc <= r_acc9;
            r_out_bad <= r_acc9 && r_win9;
            r_out_mx  <= r_acc9 ? n_px_sum[46:30] : 17'sd0;
            r_out_my  <= r_acc9 ? n_py_sum[46:30] : 17'sd0;
            r_out_mz  <= r_acc9 ? r_pz9 : 17'sd0;
            r_out_e   <= r_acc9 ? r_e9 : 16'd0;
        end
    end

    assign o_out_valid    = r_v[NS];
    assign o_accepted     = r_out_acc;
    assign o_bad_shower   = r_out_bad;
    assign o_mom_x        = r_out_mx;
    assign o_mom_y        = r_out_my;
    assign o_mom_z        = r_out_mz;
    assign o_total_energy = r_out_e;

    // checks
    logic w_out_zero;

    assign w_out_zero = (o_mom_x == 17'sd0) && (o_mom_y == 17'sd0) && (o_mom_z == 17'sd0)
                        && (o_total_energy == 16'd0) && !o_bad_shower;

    `PCS_P4_ASSERT_NOW(a_reject_is_zero, o_out_valid && !o_accepted, w_out_zero, "nonzero reject")
    `PCS_P4_ASSERT_NOW(a_stall_only_when_full, o_in_stall, (&r_v) && i_out_stall, "early stall")
    `PCS_P4_ASSERT_NEXT(a_accept_enters, i_in_valid && !o_in_stall, r_v[1], "item lost at entry")

endmodule

>>> test/tb_photon_cluster_select_p4_top.sv
`timescale 1ns / 100ps
// testbench for photon_cluster_select_p4_top: streams clusters under several cut
// settings and checks every four-momentum item against a bit-exact predictor
// depends on pcs_p4_pkg and the block's rtl only
module tb_photon_cluster_select_p4_top;

    localparam logic [pcs_p4_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic        accepted;
        logic        bad_shower;
        logic [16:0] mom_x;
        logic [16:0] mom_y;
        logic [16:0] mom_z;
        logic [15:0] total_energy;
    } t_p4_item;

    class t_cluster_p4_checker;
        logic [15:0] barrel_e_min;
        logic [15:0] endcap_e_min;
        logic [15:0] barrel_cos;
        logic [15:0] endcap_cos_lo;
        logic [15:0] endcap_cos_hi;
        t_p4_item    pending_p4[$];
        int          mismatch_count;
        int          results_seen;

        function new();
            barrel_e_min   = 16'd410;
            endcap_e_min   = 16'd819;
            barrel_cos     = 16'd26214;
            endcap_cos_lo  = 16'd28180;
            endcap_cos_hi  = 16'd30147;
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        function void write_cut(logic [pcs_p4_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                pcs_p4_pkg::CFG_BARREL_E_MIN:  barrel_e_min  = val;
                pcs_p4_pkg::CFG_ENDCAP_E_MIN:  endcap_e_min  = val;
                pcs_p4_pkg::CFG_BARREL_COS:    barrel_cos    = val;
                pcs_p4_pkg::CFG_ENDCAP_COS_LO: endcap_cos_lo = val;
                pcs_p4_pkg::CFG_ENDCAP_COS_HI: endcap_cos_hi = val;
                default: ;
            endcase
        endfunction

        function logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
            return (a * b) >> 30;
        endfunction

        // odd series on x in 0..16384 quarter-turn units, result q1.15
        function int quarter_sine(logic [14:0] x);
            logic [63:0] x30;
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] m;
            x30 = {49'd0, x} << 16;
            x2  = mul_q30(x30, x30);
            t   = pcs_p4_pkg::SIN_C9;
            t   = pcs_p4_pkg::SIN_C7 - mul_q30(x2, t);
            t   = pcs_p4_pkg::SIN_C5 - mul_q30(x2, t);
            t   = pcs_p4_pkg::SIN_C3 - mul_q30(x2, t);
            t   = pcs_p4_pkg::SIN_C1 - mul_q30(x2, t);
            m   = mul_q30(x30, t);
            m   = (m + 64'd16384) >> 15;
            if (m > 64'd32768) m = 64'd32768;
            return int'(m);
        endfunction

        function int sine_q15(logic [15:0] a);
            logic [14:0] r;
            int          m;
            r = {1'b0, a[13:0]};
            if (a[14]) r = 15'd16384 - r;
            m = quarter_sine(r);
            return a[15] ? -m : m;
        endfunction

        function int cosine_q15(logic [15:0] a);
            logic [15:0] shifted;
            shifted = a + pcs_p4_pkg::QUARTER_TURN;
            return sine_q15(shifted);
        endfunction

        // half away from zero, kept to the 17-bit field
        function logic [16:0] round_to_field(longint prod, int sh);
            logic [63:0] m;
            logic [63:0] r;
            m = (prod < 0) ? 64'(-prod) : 64'(prod);
            m = (m + (64'd1 << (sh - 1))) >> sh;
            r = (prod < 0) ? -m : m;
            return r[16:0];
        endfunction

        function t_p4_item cluster_four_momentum(logic [15:0] e, logic [15:0] theta,
                                                 logic [15:0] phi);
            t_p4_item    res;
            int          st;
            int          ct;
            int          sp;
            int          cp;
            int unsigned abs_ct;
            bit          barrel;
            bit          window;
            bit          endcap;
            longint      es;
            st     = sine_q15(theta);
            ct     = cosine_q15(theta);
            sp     = sine_q15(phi);
            cp     = cosine_q15(phi);
            abs_ct = (ct < 0) ? -ct : ct;
            barrel = (abs_ct < barrel_cos) && (e > barrel_e_min);
            window = (abs_ct > endcap_cos_lo) && (abs_ct < endcap_cos_hi);
            endcap = window && (e > endcap_e_min);
            res    = '0;
            if (barrel || endcap) begin
                es               = longint'(e) * longint'(st);
                res.accepted     = 1'b1;
                res.bad_shower   = window;
                res.mom_x        = round_to_field(es * longint'(cp), 30);
                res.mom_y        = round_to_field(es * longint'(sp), 30);
                res.mom_z        = round_to_field(longint'(e) * longint'(ct), 15);
                res.total_energy = e;
            end
            return res;
        endfunction

        function void note_cluster(logic [15:0] e, logic [15:0] theta, logic [15:0] phi);
            pending_p4.push_back(cluster_four_momentum(e, theta, phi));
        endfunction

        function int outstanding();
            return pending_p4.size();
        endfunction

        function void compare_field(string name, logic [16:0] want, logic [16:0] got);
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("item %0d: %s expected %0d, got %0d", results_seen, name,
                             $signed(want), $signed(got));
            end
        endfunction

        function void check_result(t_p4_item got);
            t_p4_item want;
            results_seen++;
            if (pending_p4.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("item %0d: result with no cluster outstanding", results_seen);
                return;
            end
            want = pending_p4.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("bad_shower", want.bad_shower, got.bad_shower);
            compare_field("mom_x", want.mom_x, got.mom_x);
            compare_field("mom_y", want.mom_y, got.mom_y);
            compare_field("mom_z", want.mom_z, got.mom_z);
            compare_field("total_energy", want.total_energy, got.total_energy);
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic [15:0]                          i_cluster_energy;
    logic [15:0]                          i_polar_angle;
    logic [15:0]                          i_azimuth_angle;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic                                 o_accepted;
    logic                                 o_bad_shower;
    logic signed [16:0]                   o_mom_x;
    logic signed [16:0]                   o_mom_y;
    logic signed [16:0]                   o_mom_z;
    logic [15:0]                          o_total_energy;
    logic                                 i_cfg_we;
    logic [pcs_p4_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [15:0]                          i_cfg_data;

    t_cluster_p4_checker sb;
    bit tx_gaps      = 1'b0;
    bit rx_gaps      = 1'b0;
    bit hold_pending = 1'b0;
    int stuck_cycles = 0;

    photon_cluster_select_p4_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cluster_energy (i_cluster_energy),
        .i_polar_angle    (i_polar_angle),
        .i_azimuth_angle  (i_azimuth_angle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_accepted       (o_accepted),
        .o_bad_shower     (o_bad_shower),
        .o_mom_x          (o_mom_x),
        .o_mom_y          (o_mom_y),
        .o_mom_z          (o_mom_z),
        .o_total_energy   (o_total_energy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // both handshakes observed at the rising edge
    always @(posedge i_clk) begin : monitor
        t_p4_item seen;
        bit       moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                sb.note_cluster(i_cluster_energy, i_polar_angle, i_azimuth_angle);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                seen.accepted     = o_accepted;
                seen.bad_shower   = o_bad_shower;
                seen.mom_x        = o_mom_x;
                seen.mom_y        = o_mom_y;
                seen.mom_z        = o_mom_z;
                seen.total_energy = o_total_energy;
                sb.check_result(seen);
                moved = 1'b1;
            end
            stuck_cycles <= moved ? 0 : stuck_cycles + 1;
        end
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("tb_photon_cluster_select_p4_top failed");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic sender_gap(input int n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_cluster(input logic [15:0] e, input logic [15:0] theta,
                                input logic [15:0] phi);
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_cluster_energy <= e;
        i_polar_angle    <= theta;
        i_azimuth_angle  <= phi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (tx_gaps && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 17));
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cut(input logic [pcs_p4_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_cut(idx, val);
    endtask

    task automatic set_cuts(input logic [15:0] bem, input logic [15:0] eem,
                            input logic [15:0] bcos, input logic [15:0] elo,
                            input logic [15:0] ehi);
        write_cut(pcs_p4_pkg::CFG_BARREL_E_MIN, bem);
        write_cut(pcs_p4_pkg::CFG_ENDCAP_E_MIN, eem);
        write_cut(pcs_p4_pkg::CFG_BARREL_COS, bcos);
        write_cut(pcs_p4_pkg::CFG_ENDCAP_COS_LO, elo);
        write_cut(pcs_p4_pkg::CFG_ENDCAP_COS_HI, ehi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // energies cluster around the current thresholds part of the time
    function automatic logic [15:0] pick_energy();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 2047));
            1: return 16'(sb.barrel_e_min + $urandom_range(0, 4) - 2);
            2: return 16'(sb.endcap_e_min + $urandom_range(0, 4) - 2);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // polar angles lean toward the forward and backward endcap regions
    function automatic logic [15:0] pick_theta();
        logic [15:0] base;
        base = 16'($urandom_range(3000, 7500));
        case ($urandom_range(0, 7))
            0, 1: return ($urandom_range(0, 1) != 0) ? base : 16'd32768 - base;
            2: return 16'($urandom_range(0, 65535));
            3: return 16'($urandom_range(0, 4) * 16384);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++)
            send_cluster(pick_energy(), pick_theta(), 16'($urandom_range(0, 65535)));
    endtask

    task automatic pick_idling();
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        sb = new();
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_cluster_energy <= '0;
        i_polar_angle    <= '0;
        i_azimuth_angle  <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset cuts
        send_cluster(16'd0, 16'd16384, 16'd0);
        send_cluster(16'd65535, 16'd16384, 16'd0);
        send_cluster(16'd65535, 16'd16384, 16'd32768);
        send_cluster(16'd65535, 16'd16384, 16'd16384);
        send_cluster(16'd65535, 16'd16384, 16'd49152);
        send_cluster(16'd65535, 16'd16384, 16'd65535);
        send_cluster(16'd410, 16'd16384, 16'd1000);
        send_cluster(16'd411, 16'd16384, 16'd1000);
        send_cluster(16'd65535, 16'd0, 16'd0);
        send_cluster(16'd65535, 16'd32768, 16'd0);
        send_cluster(16'd900, 16'd4939, 16'd7000);
        send_cluster(16'd819, 16'd4939, 16'd7000);
        send_cluster(16'd820, 16'd27829, 16'd7000);
        send_cluster(16'd600, 16'd4939, 16'd0);
        send_cluster(16'd30000, 16'd6710, 16'd12345);
        send_cluster(16'd30000, 16'd6711, 16'd12345);
        send_cluster(16'd30000, 16'd6712, 16'd12345);
        send_cluster(16'd30000, 16'd40000, 16'd20000);
        send_cluster(16'd30000, 16'd65535, 16'd50000);
        send_cluster(16'd65535, 16'd49152, 16'd8192);
        send_cluster(16'hFFFF, 16'h7FFF, 16'hAAAA);
        send_cluster(16'd1, 16'd16384, 16'h5555);
        send_cluster(16'h8000, 16'd10000, 16'hFFFF);

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_random(80);

        // long output hold while clusters keep coming, so the pipe backs up
        tx_gaps      = 1'b0;
        hold_pending = 1'b1;
        run_random(40);
        pause_until_drained();
        tx_gaps = 1'b1;
        run_random(30);

        // everything closed: nothing can pass
        pause_until_drained();
        pick_idling();
        set_cuts(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(60);

        // barrel wide open, endcap energy cut unreachable
        pause_until_drained();
        pick_idling();
        set_cuts(16'd0, 16'd65535, 16'd32768, 16'd0, 16'd32768);
        run_random(90);

        // endcap window over the full range, barrel shut by energy
        pause_until_drained();
        pick_idling();
        set_cuts(16'd65535, 16'd0, 16'd0, 16'd0, 16'd32768);
        run_random(90);

        // overlapping regions: barrel-only and both-pass cases in the window
        pause_until_drained();
        pick_idling();
        set_cuts(16'd100, 16'd20000, 16'd31000, 16'd28000, 16'd32000);
        run_random(90);

        // cosine limits past one never exclude
        pause_until_drained();
        pick_idling();
        set_cuts(16'd1000, 16'd1000, 16'd65535, 16'd32767, 16'd65535);
        run_random(80);

        // random cuts, plus a write to an unused index that must be ignored
        pause_until_drained();
        pick_idling();
        set_cuts(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                 16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                 16'($urandom_range(0, 32768)));
        write_cut(CFG_IDX_SPARE, 16'($urandom_range(0, 65535)));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        run_random(90);

        // back to the reset cuts, full rate on both sides
        pause_until_drained();
        set_cuts(16'd410, 16'd819, 16'd26214, 16'd28180, 16'd30147);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random(80);

        pause_until_drained();
        repeat (pcs_p4_pkg::PIPE_STAGES + 10) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("tb_photon_cluster_select_p4_top passed");
        else
            $display("tb_photon_cluster_select_p4_top failed");
        $finish;
    end
endmodule
